// ----- src/gdmd_pkg.sv -----
// Package for the Gregorian date minus days unit.
// Holds shared constants, the sideband struct and the month start table.
// No dependencies.
`default_nettype none
package gdmd_pkg;

    localparam int unsigned MAX_YEAR   = 9999;
    localparam int unsigned CYCLE_DAYS = 146097;
    localparam int unsigned CENT_DAYS  = 36524;
    localparam int unsigned QUAD_DAYS  = 1461;
    localparam int unsigned YEAR_DAYS  = 365;

    // Fields collected along the day-count split.
    typedef struct packed {
        logic       uf;
        logic [4:0] cyc;
        logic [2:0] cent;
        logic [4:0] q4;
    } t_side;

    // Zero-based day of year at which month m starts in a common year.
    function automatic logic [8:0] cum_start(input logic [3:0] m);
        logic [8:0] v;
        begin
            case (m)
                4'd1:    v = 9'd0;
                4'd2:    v = 9'd31;
                4'd3:    v = 9'd59;
                4'd4:    v = 9'd90;
                4'd5:    v = 9'd120;
                4'd6:    v = 9'd151;
                4'd7:    v = 9'd181;
                4'd8:    v = 9'd212;
                4'd9:    v = 9'd243;
                4'd10:   v = 9'd273;
                4'd11:   v = 9'd304;
                4'd12:   v = 9'd334;
                default: v = 9'd0;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

// ----- src/gdmd_serial.sv -----
// Date to zero-based day count minus offset, four register stages.
// Depends on gdmd_pkg.
`default_nettype none
module gdmd_serial
    import gdmd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire logic [4:0]  i_day,
    input  wire logic [3:0]  i_month,
    input  wire logic [13:0] i_year,
    input  wire logic [21:0] i_offset,
    output logic             o_valid,
    output logic [21:0]      o_n,
    output logic             o_uf
);

    // Reciprocal of 100 scaled by 2^24, exact for values below 2^14.
    localparam logic [17:0] RECIP_100 = 18'd167773;

    logic [3:0]  n_m;
    logic [13:0] n_y;

    logic        r1_v;
    logic [4:0]  r1_d;
    logic [3:0]  r1_m;
    logic [13:0] r1_y;
    logic [13:0] r1_p;
    logic [21:0] r1_off;

    logic        r2_v;
    logic [4:0]  r2_d;
    logic [3:0]  r2_m;
    logic [13:0] r2_y;
    logic [13:0] r2_p;
    logic [21:0] r2_off;
    logic [6:0]  r2_qy;
    logic [6:0]  r2_qp;

    logic        r3_v;
    logic [4:0]  r3_d;
    logic [21:0] r3_off;
    logic [21:0] r3_p365;
    logic [11:0] r3_leaps;
    logic [8:0]  r3_cum;

    logic [31:0] prod_y;
    logic [31:0] prod_p;
    logic [13:0] ry;
    logic        leap;
    logic [22:0] serial;
    logic [23:0] diff;

    always_comb begin
        n_m = i_month;
        if (i_month < 4'd1) n_m = 4'd1;
        if (i_month > 4'd12) n_m = 4'd12;
        n_y = i_year;
        if (i_year < 14'd1) n_y = 14'd1;
        if (i_year > 14'(MAX_YEAR)) n_y = 14'(MAX_YEAR);
    end

    assign prod_y = 32'(r1_y) * 32'(RECIP_100);
    assign prod_p = 32'(r1_p) * 32'(RECIP_100);

    assign ry   = r2_y - 14'(r2_qy * 14'd100);
    assign leap = ((r2_y[1:0] == 2'b00) && (ry != 14'd0)) ||
                  ((ry == 14'd0) && (r2_qy[1:0] == 2'b00));

    assign serial = 23'(r3_p365) + 23'(r3_leaps) + 23'(r3_cum) + 23'(r3_d);
    assign diff   = 24'(serial) - 24'(r3_off);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r1_v    <= i_valid;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            o_valid <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_d   <= i_day;
            r1_m   <= n_m;
            r1_y   <= n_y;
            r1_p   <= n_y - 14'd1;
            r1_off <= i_offset;

            r2_d   <= r1_d;
            r2_m   <= r1_m;
            r2_y   <= r1_y;
            r2_p   <= r1_p;
            r2_off <= r1_off;
            r2_qy  <= prod_y[30:24];
            r2_qp  <= prod_p[30:24];

            r3_d     <= r2_d;
            r3_off   <= r2_off;
            r3_p365  <= 22'(r2_p) * 22'd365;
            r3_leaps <= 12'(r2_p[13:2]) - 12'(r2_qp) + 12'(r2_qp[6:2]);
            r3_cum   <= cum_start(r2_m) + 9'((leap && (r2_m > 4'd2)) ? 1 : 0);

            // A result of zero or below lies before the first day.
            o_uf <= diff[23] || (diff == 24'd0);
            o_n  <= diff[21:0] - 22'd1;
        end
    end

endmodule
`default_nettype wire

// ----- src/gdmd_divstep.sv -----
// One constant division in three stages: reciprocal estimate, remainder,
// single correction with optional clamp of a quotient of four. Uses gdmd_pkg.
`default_nettype none
module gdmd_divstep
    import gdmd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire logic [21:0] i_num,
    input  wire t_side       i_side,
    input  wire logic [17:0] i_div,
    input  wire logic [5:0]  i_recip,
    input  wire logic [4:0]  i_shift,
    input  wire logic        i_clamp,
    output logic             o_valid,
    output logic [5:0]       o_q,
    output logic [21:0]      o_rem,
    output t_side            o_side
);

    logic        r_a_v;
    logic [21:0] r_a_num;
    logic [5:0]  r_a_qe;
    t_side       r_a_side;

    logic        r_b_v;
    logic [21:0] r_b_rem;
    logic [5:0]  r_b_qe;
    t_side       r_b_side;

    logic [27:0] prod;
    logic [23:0] back;
    logic [5:0]  n_q;
    logic [21:0] n_rem;

    assign prod = 28'(i_num) * 28'(i_recip);
    assign back = 24'(r_a_qe) * 24'(i_div);

    // The estimate is never above the true quotient and at most one below.
    always_comb begin
        n_q   = r_b_qe;
        n_rem = r_b_rem;
        if (r_b_rem >= 22'(i_div)) begin
            n_q   = r_b_qe + 6'd1;
            n_rem = r_b_rem - 22'(i_div);
        end
        if (i_clamp && (n_q == 6'd4)) begin
            n_q   = 6'd3;
            n_rem = n_rem + 22'(i_div);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_a_v   <= i_valid;
            r_b_v   <= r_a_v;
            o_valid <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_num  <= i_num;
            r_a_qe   <= 6'(prod >> i_shift);
            r_a_side <= i_side;

            r_b_rem  <= r_a_num - back[21:0];
            r_b_qe   <= r_a_qe;
            r_b_side <= r_a_side;

            o_q    <= n_q;
            o_rem  <= n_rem;
            o_side <= r_b_side;
        end
    end

endmodule
`default_nettype wire

// ----- src/gdmd_month.sv -----
// Rebuilds year, month and day from the split day count, three stages.
// Depends on gdmd_pkg.
`default_nettype none
module gdmd_month
    import gdmd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire t_side       i_side,
    input  wire logic [5:0]  i_yy,
    input  wire logic [21:0] i_doy,
    output logic             o_valid,
    output logic [4:0]       o_day,
    output logic [3:0]       o_month,
    output logic [13:0]      o_year,
    output logic             o_uf
);

    logic        r1_v;
    logic        r1_uf;
    logic        r1_leap;
    logic [13:0] r1_year;
    logic [8:0]  r1_doy;

    logic        r2_v;
    logic        r2_uf;
    logic        r2_leap;
    logic [13:0] r2_year;
    logic [8:0]  r2_doy;
    logic [3:0]  r2_m;

    logic [3:0]  n_m;
    logic [8:0]  start;
    logic [8:0]  dd;

    always_comb begin
        n_m = 4'd1;
        for (int k = 2; k <= 12; k++) begin
            if (r1_doy >= cum_start(4'(k)) + 9'((r1_leap && (k > 2)) ? 1 : 0)) begin
                n_m = 4'(k);
            end
        end
    end

    assign start = cum_start(r2_m) + 9'((r2_leap && (r2_m > 4'd2)) ? 1 : 0);
    assign dd    = r2_doy - start + 9'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r1_v    <= i_valid;
            r2_v    <= r1_v;
            o_valid <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_uf   <= i_side.uf;
            r1_year <= 14'd1 + 14'(i_side.cyc * 14'd400) + 14'(i_side.cent * 14'd100)
                       + 14'({i_side.q4, 2'b00}) + 14'(i_yy);
            // Last year of a four-year group is leap unless it closes a
            // century that is not a multiple of four hundred.
            r1_leap <= (i_yy == 6'd3) && ((i_side.q4 != 5'd24) || (i_side.cent == 3'd3));
            r1_doy  <= i_doy[8:0];

            r2_uf   <= r1_uf;
            r2_leap <= r1_leap;
            r2_year <= r1_year;
            r2_doy  <= r1_doy;
            r2_m    <= n_m;

            o_uf    <= r2_uf;
            o_day   <= r2_uf ? 5'd1  : dd[4:0];
            o_month <= r2_uf ? 4'd1  : r2_m;
            o_year  <= r2_uf ? 14'd1 : r2_year;
        end
    end

endmodule
`default_nettype wire

// ----- src/gregorian_date_minus_days_unit.sv -----
// Top level of the Gregorian date minus days unit.
// Depends on gdmd_pkg, gdmd_serial, gdmd_divstep and gdmd_month.
`default_nettype none
//
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_ready   i_day_in, i_month_in, i_year_in,
//                                          i_offset_days
// result    out        o_valid / i_ready   o_day_out, o_month_out, o_year_out,
//                                          o_underflow
//
// One item can enter every cycle while o_ready is high. Four stages form
// the serial day count, four division units of three stages each split it
// into 400-year cycles, centuries, four-year groups and years, and three
// stages find month and day.
// The whole pipeline advances together whenever the output register is empty
// or its result is taken, so a stall holds every stage and loses nothing.
// Reset clears only the valid bits of every stage.
module gregorian_date_minus_days_unit
    import gdmd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [4:0]  i_day_in,
    input  wire logic [3:0]  i_month_in,
    input  wire logic [13:0] i_year_in,
    input  wire logic [21:0] i_offset_days,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [4:0]       o_day_out,
    output logic [3:0]       o_month_out,
    output logic [13:0]      o_year_out,
    output logic             o_underflow
);

    logic        en;

    logic        s_v;
    logic [21:0] s_n;
    logic        s_uf;
    t_side       s_side;

    logic        c_v, e_v, q_v, y_v;
    logic [5:0]  c_q, e_q, q_q, y_q;
    logic [21:0] c_rem, e_rem, q_rem, y_rem;
    t_side       c_side, e_side, q_side, y_side;
    t_side       c_in, e_in, q_in;

    // Every stage moves when the output register can take a new value.
    assign en      = i_ready || !o_valid;
    assign o_ready = en;

    gdmd_serial u_serial (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_day    (i_day_in),
        .i_month  (i_month_in),
        .i_year   (i_year_in),
        .i_offset (i_offset_days),
        .o_valid  (s_v),
        .o_n      (s_n),
        .o_uf     (s_uf)
    );

    always_comb begin
        s_side      = '0;
        s_side.uf   = s_uf;
        c_in        = c_side;
        c_in.cyc    = c_q[4:0];
        e_in        = e_side;
        e_in.cent   = e_q[2:0];
        q_in        = q_side;
        q_in.q4     = q_q[4:0];
    end

    // Whole 400-year cycles.
    gdmd_divstep u_div_cycle (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
        .i_valid (s_v), .i_num (s_n), .i_side (s_side),
        .i_div (18'(CYCLE_DAYS)), .i_recip (6'd28), .i_shift (5'd22), .i_clamp (1'b0),
        .o_valid (c_v), .o_q (c_q), .o_rem (c_rem), .o_side (c_side)
    );

    // Centuries; the last day of a cycle stays in the fourth century.
    gdmd_divstep u_div_cent (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
        .i_valid (c_v), .i_num (c_rem), .i_side (c_in),
        .i_div (18'(CENT_DAYS)), .i_recip (6'd7), .i_shift (5'd18), .i_clamp (1'b1),
        .o_valid (e_v), .o_q (e_q), .o_rem (e_rem), .o_side (e_side)
    );

    // Four-year groups.
    gdmd_divstep u_div_quad (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
        .i_valid (e_v), .i_num (e_rem), .i_side (e_in),
        .i_div (18'(QUAD_DAYS)), .i_recip (6'd44), .i_shift (5'd16), .i_clamp (1'b0),
        .o_valid (q_v), .o_q (q_q), .o_rem (q_rem), .o_side (q_side)
    );

    // Years; the last day of a leap group stays in its fourth year.
    gdmd_divstep u_div_year (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
        .i_valid (q_v), .i_num (q_rem), .i_side (q_in),
        .i_div (18'(YEAR_DAYS)), .i_recip (6'd5), .i_shift (5'd11), .i_clamp (1'b1),
        .o_valid (y_v), .o_q (y_q), .o_rem (y_rem), .o_side (y_side)
    );

    gdmd_month u_month (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (y_v),
        .i_side  (y_side),
        .i_yy    (y_q),
        .i_doy   (y_rem),
        .o_valid (o_valid),
        .o_day   (o_day_out),
        .o_month (o_month_out),
        .o_year  (o_year_out),
        .o_uf    (o_underflow)
    );

endmodule
`default_nettype wire
